/* rtl/rtpv_pkg.sv */
// rtpv_pkg: shared widths, constants, opcodes and the window entry type
// for the rtp stream validator; no dependencies
package rtpv_pkg;

	localparam int FMT_W   = 14;
	localparam int SRC_W   = 32;
	localparam int SEQ_W   = 16;
	localparam int TS_W    = 32;
	localparam int NOISE_W = 4;
	localparam int CNT_W   = 32;
	localparam int VER_W   = 2;
	localparam int HLEN_W  = 8;
	localparam int CSRC_W  = 4;

	// noise limit after reset, default window depth
	localparam int RESET_NOISE_LIMIT    = 1;
	localparam int DEFAULT_WINDOW_DEPTH = 4;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_DETECT = 1'b1;

	typedef struct packed {
		logic [FMT_W-1:0] fmt;
		logic [SRC_W-1:0] src;
		logic [SEQ_W-1:0] seq;
		logic [TS_W-1:0]  ts;
	} entry_t;

endpackage

/* rtl/rtpv_in_if.sv */
// rtpv_in_if: valid/ready channel carrying one parsed packet header item
// depends on rtpv_pkg
interface rtpv_in_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic                          parse_ok;
	logic [rtpv_pkg::VER_W-1:0]    version;
	logic [rtpv_pkg::HLEN_W-1:0]   header_length;
	logic [rtpv_pkg::CSRC_W-1:0]   csrc_count;
	logic [rtpv_pkg::SRC_W-1:0]    ssrc;
	logic [rtpv_pkg::SEQ_W-1:0]    sequence_number;
	logic [rtpv_pkg::TS_W-1:0]     rtp_timestamp;

	modport source (output valid, opcode, parse_ok, version, header_length, csrc_count,
		ssrc, sequence_number, rtp_timestamp, input ready);
	modport sink (input valid, opcode, parse_ok, version, header_length, csrc_count,
		ssrc, sequence_number, rtp_timestamp, output ready);
endinterface

/* rtl/rtpv_out_if.sv */
// rtpv_out_if: valid/ready channel carrying one stream status item
// depends on rtpv_pkg
interface rtpv_out_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic                          stream_valid;
	logic [rtpv_pkg::CNT_W-1:0]    received_count;
	logic [rtpv_pkg::SEQ_W-1:0]    lowest_sequence;
	logic [rtpv_pkg::SEQ_W-1:0]    highest_sequence;
	logic [rtpv_pkg::SRC_W-1:0]    stream_ssrc;

	modport source (output valid, accepted, stream_valid, received_count, lowest_sequence,
		highest_sequence, stream_ssrc, input ready);
	modport sink (input valid, accepted, stream_valid, received_count, lowest_sequence,
		highest_sequence, stream_ssrc, output ready);
endinterface

/* rtl/rtpv_cell.sv */
// rtpv_cell: one window slot of the packet chain, loads from its newer
// neighbor and checks itself against it; depends on rtpv_pkg
module rtpv_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  rtpv_pkg::entry_t nbr,
	output rtpv_pkg::entry_t entry,
	output logic             pair_ok
);
	import rtpv_pkg::*;

	entry_t          entry_q;
	logic            seq_neg;
	logic [TS_W-1:0] ts_diff;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= nbr;
		end
	end

	// neighbor is the newer packet, this slot the older one
	always_comb begin
		seq_neg = nbr.seq < entry_q.seq;
		ts_diff = nbr.ts - entry_q.ts;
		pair_ok = (nbr.fmt == entry_q.fmt) && (nbr.src == entry_q.src) &&
			(seq_neg == ts_diff[TS_W-1]);
	end

	assign entry = entry_q;

endmodule

/* rtl/rtp_stream_validator.sv */
// rtp_stream_validator: top level, packet window chain plus stream control
// depends on rtpv_pkg, rtpv_in_if, rtpv_out_if, rtpv_cell
//
// channel   dir  handshake          payload
// item      in   valid/ready        opcode, parse_ok, header fields, seq, timestamp
// result    out  valid/ready        accepted, stream_valid, count, seq range, ssrc
// cfg       in   cfg_we only        cfg_wdata = noise limit
//
// a packet item gives its result in the cycle after it is taken
// a detect item on a full window rotates the cell chain through a full turn past
//   the min/max scanner, result in the cycle after the last step; on a window
//   that is not full it fails at once like a packet item
// reset clears all control state, noise limit returns to one, window slots
//   hold junk until packets shift in
// a new item is taken only when no result waits or the waiting one leaves
//   in the same cycle; one item is in flight at a time
module rtp_stream_validator #(
	parameter int WINDOW_PACKETS = rtpv_pkg::DEFAULT_WINDOW_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rtpv_in_if.sink                      item,
	rtpv_out_if.source                   result,
	input  logic                         cfg_we,
	input  logic [rtpv_pkg::NOISE_W-1:0] cfg_wdata
);
	import rtpv_pkg::*;

	localparam int FILL_W = $clog2(WINDOW_PACKETS + 1);
	localparam int SCAN_W = $clog2(WINDOW_PACKETS);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_PACKETS);
	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(WINDOW_PACKETS - 1);
	localparam logic [SEQ_W:0]    SPAN_MIN  = (SEQ_W + 1)'(WINDOW_PACKETS - 2);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_PACKETS);
	localparam logic [SEQ_W-1:0]  SEQ_TOP   = '1;
	localparam logic [NOISE_W-1:0] NOISE_TOP = '1;

	// control states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	// control
	logic               state_q;
	logic [SCAN_W-1:0]  scan_cnt_q;
	logic [FILL_W-1:0]  fill_q;
	logic               out_valid_q;
	logic [NOISE_W-1:0] limit_q;

	// stream state, shown directly on the result channel
	logic               valid_q;
	logic               acc_q;
	logic [NOISE_W-1:0] noise_q;
	logic [SEQ_W-1:0]   min_q;
	logic [SEQ_W-1:0]   max_q;
	logic [CNT_W-1:0]   count_q;
	logic [SRC_W-1:0]   ssrc_q;

	// detection scratch
	logic               pair_ok_q;
	logic [SEQ_W-1:0]   scan_min_q;
	logic [SEQ_W-1:0]   scan_max_q;

	entry_t                    new_entry;
	entry_t                    chain_in  [WINDOW_PACKETS];
	entry_t                    chain_out [WINDOW_PACKETS];
	logic [WINDOW_PACKETS-1:0] pair_ok;
	logic                      window_ok;
	logic                      take;
	logic                      shift_en;

	logic               have_entry;
	logic               same;
	logic               noise_in;
	logic               dup;
	logic               keep;
	logic [NOISE_W-1:0] noise_inc;
	logic               noise_trip;

	entry_t             tail;
	logic [SEQ_W-1:0]   fmin;
	logic [SEQ_W-1:0]   fmax;
	logic               span_ok;
	logic               scan_done;

	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign take       = item.valid && item.ready;

	assign new_entry.fmt = {item.version, item.header_length, item.csrc_count};
	assign new_entry.src = item.ssrc;
	assign new_entry.seq = item.sequence_number;
	assign new_entry.ts  = item.rtp_timestamp;

	// packet classification against the newest slot (cell 0)
	always_comb begin
		have_entry = fill_q != '0;
		same       = have_entry && (chain_out[0].fmt == new_entry.fmt) &&
			(chain_out[0].src == new_entry.src);
		noise_in   = !item.parse_ok || (have_entry && valid_q && !same);
		dup        = !noise_in && same && (chain_out[0].seq >= new_entry.seq);
		keep       = !noise_in && !dup;
		noise_inc  = (noise_q == NOISE_TOP) ? noise_q : noise_q + 1'b1;
		noise_trip = noise_inc > limit_q;
	end

	// chain: cell 0 takes a new packet, or the tail while rotating for a scan
	assign shift_en = (take && item.opcode == OP_PACKET && keep) || (state_q == ST_SCAN);
	assign tail     = chain_out[WINDOW_PACKETS-1];

	always_comb begin
		for (int k = 0; k < WINDOW_PACKETS; k++) begin
			if (k == 0) begin
				chain_in[k] = (state_q == ST_SCAN) ? tail : new_entry;
			end else begin
				chain_in[k] = chain_out[k-1];
			end
		end
	end

	for (genvar g = 0; g < WINDOW_PACKETS; g++) begin : g_cell
		rtpv_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.nbr      (chain_in[g]),
			.entry    (chain_out[g]),
			.pair_ok  (pair_ok[g])
		);
	end

	// every neighbor pair must agree; cell 0 has no newer partner in the window
	always_comb begin
		window_ok = 1'b1;
		for (int k = 1; k < WINDOW_PACKETS; k++) begin
			window_ok = window_ok && pair_ok[k];
		end
	end

	// min/max scanner at the chain tail
	always_comb begin
		fmin      = (tail.seq < scan_min_q) ? tail.seq : scan_min_q;
		fmax      = (tail.seq > scan_max_q) ? tail.seq : scan_max_q;
		span_ok   = ({1'b0, fmin} + SPAN_MIN) <= {1'b0, fmax};
		scan_done = (state_q == ST_SCAN) && (scan_cnt_q == SCAN_LAST);
	end

	always_ff @(posedge clk) begin
		if (take && item.opcode == OP_DETECT) begin
			pair_ok_q  <= window_ok;
			scan_min_q <= SEQ_TOP;
			scan_max_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_min_q <= fmin;
			scan_max_q <= fmax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= NOISE_W'(RESET_NOISE_LIMIT);
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_cnt_q  <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			valid_q     <= 1'b0;
			acc_q       <= 1'b0;
			noise_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			count_q     <= '0;
			ssrc_q      <= '0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (item.opcode == OP_PACKET) begin
					out_valid_q <= 1'b1;
					priority if (noise_in) begin
						// noise only matters on a qualified stream
						if (!valid_q) begin
							acc_q <= 1'b0;
						end else if (noise_trip) begin
							acc_q   <= 1'b0;
							valid_q <= 1'b0;
							min_q   <= SEQ_TOP;
							max_q   <= '0;
							noise_q <= '0;
						end else begin
							acc_q   <= 1'b1;
							noise_q <= noise_inc;
						end
					end else if (dup) begin
						acc_q <= 1'b1;
					end else begin
						acc_q   <= 1'b1;
						noise_q <= '0;
						fill_q  <= (fill_q == FILL_FULL) ? FILL_FULL : fill_q + 1'b1;
						if (new_entry.seq < min_q) begin
							min_q <= new_entry.seq;
						end
						if (new_entry.seq > max_q) begin
							max_q <= new_entry.seq;
						end
						count_q <= count_q + 1'b1;
					end
				end else if (fill_q != FILL_FULL) begin
					// partial window fails detection at once
					out_valid_q <= 1'b1;
					acc_q       <= 1'b0;
					valid_q     <= 1'b0;
					min_q       <= SEQ_TOP;
					max_q       <= '0;
					noise_q     <= '0;
				end else begin
					out_valid_q <= 1'b0;
					state_q     <= ST_SCAN;
					scan_cnt_q  <= '0;
				end
			end
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
				if (scan_done) begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
					if (pair_ok_q && span_ok) begin
						acc_q   <= 1'b1;
						valid_q <= 1'b1;
						min_q   <= fmin;
						max_q   <= fmax;
						count_q <= CNT_FULL;
						// last slot scanned is the newest packet
						ssrc_q  <= tail.src;
					end else begin
						acc_q   <= 1'b0;
						valid_q <= 1'b0;
						min_q   <= SEQ_TOP;
						max_q   <= '0;
						noise_q <= '0;
					end
				end
			end
		end
	end

	assign result.valid            = out_valid_q;
	assign result.accepted         = acc_q;
	assign result.stream_valid     = valid_q;
	assign result.received_count   = count_q;
	assign result.lowest_sequence  = min_q;
	assign result.highest_sequence = max_q;
	assign result.stream_ssrc      = ssrc_q;

endmodule

/* rtl/rtpv_checker.sv */
// rtpv_checker: port-level assertions for the rtp stream validator, bound
// to the top level; depends on rtpv_pkg
module rtpv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        res_accepted,
	input logic                        res_stream_valid,
	input logic [rtpv_pkg::CNT_W-1:0]  res_count,
	input logic [rtpv_pkg::SEQ_W-1:0]  res_lowest,
	input logic [rtpv_pkg::SEQ_W-1:0]  res_highest,
	input logic [rtpv_pkg::SRC_W-1:0]  res_ssrc
);
	import rtpv_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its count, range and flags
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_count) && $stable(res_lowest) &&
			$stable(res_highest) && $stable(res_accepted) && $stable(res_stream_valid))
		else $error("result payload changed while stalled");

	// a qualified stream always has an ordered sequence range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stream_valid |-> res_lowest <= res_highest)
		else $error("valid stream with inverted sequence range");

	// the ssrc is only latched by a successful detection
	a_ssrc: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(res_ssrc) |-> res_stream_valid)
		else $error("ssrc changed without stream qualification");

endmodule

bind rtp_stream_validator rtpv_checker u_rtpv_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.res_accepted     (result.accepted),
	.res_stream_valid (result.stream_valid),
	.res_count        (result.received_count),
	.res_lowest       (result.lowest_sequence),
	.res_highest      (result.highest_sequence),
	.res_ssrc         (result.stream_ssrc)
);
